/* rtl/frc_pkg.sv */
package frc_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 8;
  localparam int unsigned FRAME_OUT_W     = 64;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE_TICKS = 2'd2;

  localparam logic [3:0]  RETRY_LIMIT_RST    = 4'd5;
  localparam logic [15:0] TIMEOUT_COUNT_RST  = 16'd50;
  localparam logic [7:0]  PRESCALE_TICKS_RST = 8'd4;

  // command codes
  localparam logic [2:0] CMD_TICK = 3'd0;
  localparam logic [2:0] CMD_POLL = 3'd1;
  localparam logic [2:0] CMD_SEND = 3'd2;
  localparam logic [2:0] CMD_ACK  = 3'd3;
  localparam logic [2:0] CMD_NACK = 3'd4;

  // link states
  localparam logic [1:0] LINK_IDLE    = 2'd0;
  localparam logic [1:0] LINK_WAITING = 2'd1;
  localparam logic [1:0] LINK_NACKED  = 2'd2;

  typedef struct packed {
    logic [FRAME_OUT_W-1:0] frame_out;
    logic                   is_retry;
    logic [3:0]             attempt_number;
    logic                   gave_up;
  } res_t;

endpackage

/* rtl/frc_core.sv */
module frc_core import frc_pkg::*; #(
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  accept_i,
  input  logic [2:0]            cmd_i,
  input  logic [63:0]           frame_in_i,
  output logic                  res_valid_o,
  output res_t                  res_o
);

  localparam int unsigned FRAME_W = 8 * FRAME_BYTES;

  logic [3:0]         retry_limit_q;
  logic [15:0]        timeout_count_q;
  logic [7:0]         prescale_ticks_q;

  logic [1:0]         link_q, link_d;
  logic [3:0]         retries_q, retries_d;
  logic [FRAME_W-1:0] saved_q, saved_d;
  logic [7:0]         presc_q, presc_d;
  logic [15:0]        cd_q, cd_d;
  logic               exp_q, exp_d;

  logic [7:0]         presc_inc;
  logic [15:0]        cd_dec;
  logic               do_retry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_limit_q    <= RETRY_LIMIT_RST;
      timeout_count_q  <= TIMEOUT_COUNT_RST;
      prescale_ticks_q <= PRESCALE_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_RETRY_LIMIT:    retry_limit_q    <= cfg_data_i[3:0];
        CFG_TIMEOUT_COUNT:  timeout_count_q  <= cfg_data_i;
        CFG_PRESCALE_TICKS: prescale_ticks_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign presc_inc = presc_q + 8'd1;
  assign cd_dec    = cd_q - 16'd1;
  // an unreachable link code acts as waiting
  assign do_retry  = (link_q == LINK_NACKED) || ((link_q != LINK_IDLE) && exp_q);

  always_comb begin
    link_d      = link_q;
    retries_d   = retries_q;
    saved_d     = saved_q;
    presc_d     = presc_q;
    cd_d        = cd_q;
    exp_d       = exp_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (accept_i) begin
      case (cmd_i)
        CMD_TICK: begin
          if (presc_inc >= prescale_ticks_q) begin
            presc_d = '0;
            cd_d    = cd_dec;
            if (cd_dec == 16'd0) exp_d = 1'b1;
          end else begin
            presc_d = presc_inc;
          end
        end
        CMD_POLL: begin
          if (link_q == LINK_IDLE) begin
            retries_d = '0;
          end else if (do_retry) begin
            res_valid_o = 1'b1;
            if (retries_q < retry_limit_q) begin
              retries_d            = retries_q + 4'd1;
              res_o.frame_out      = FRAME_OUT_W'(saved_q);
              res_o.is_retry       = 1'b1;
              res_o.attempt_number = retries_q + 4'd1;
              cd_d                 = timeout_count_q;
              presc_d              = '0;
              exp_d                = 1'b0;
            end else begin
              // out of retries: report and drop back to idle
              link_d               = LINK_IDLE;
              res_o.attempt_number = retries_q;
              res_o.gave_up        = 1'b1;
            end
          end
        end
        CMD_SEND: begin
          saved_d         = frame_in_i[FRAME_W-1:0];
          res_valid_o     = 1'b1;
          res_o.frame_out = FRAME_OUT_W'(frame_in_i[FRAME_W-1:0]);
          cd_d            = timeout_count_q;
          presc_d         = '0;
          exp_d           = 1'b0;
          retries_d       = '0;
          link_d          = LINK_WAITING;
        end
        CMD_ACK:  link_d = LINK_IDLE;
        CMD_NACK: link_d = LINK_NACKED;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q    <= LINK_IDLE;
      retries_q <= '0;
      saved_q   <= '0;
      presc_q   <= '0;
      cd_q      <= '0;
      exp_q     <= 1'b0;
    end else begin
      link_q    <= link_d;
      retries_q <= retries_d;
      saved_q   <= saved_d;
      presc_q   <= presc_d;
      cd_q      <= cd_d;
      exp_q     <= exp_d;
    end
  end

endmodule

/* rtl/frc_out_buf.sv */
module frc_out_buf import frc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t push_data_i,
  output logic ready_o,
  output logic valid_o,
  input  logic pop_ready_i,
  output res_t data_o
);

  logic [1:0] cnt_q, cnt_d, cnt_pop;
  res_t       head_q, head_d;
  res_t       skid_q, skid_d;
  logic       pop;

  assign pop     = (cnt_q != 2'd0) && pop_ready_i;
  assign cnt_pop = cnt_q - {1'b0, pop};
  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = head_q;

  always_comb begin
    head_d = head_q;
    skid_d = skid_q;
    cnt_d  = cnt_pop + {1'b0, push_i};
    // advance the skid entry into the head on a transfer
    if (pop) head_d = skid_q;
    if (push_i) begin
      if (cnt_pop == 2'd0) head_d = push_data_i;
      else                 skid_d = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

endmodule

/* rtl/frame_retransmit_controller.sv */
// Frame retransmit controller.
// Input channel (in_valid_i / in_ready_o) carries one command per transfer:
// tick, poll, send (with frame_in_i), ack or nack. Output channel
// (out_valid_o / out_ready_i) carries a frame to transmit, a retransmission,
// or a give-up report. Only send and some polls produce a result.
// Each command is processed in the cycle it is accepted; its result is registered
// in the output buffer. One command per cycle is sustained while an entry is free.
// Results go through a two-entry output buffer: while one result waits for
// the receiver, the block still takes the next command. When the receiver
// stalls and both entries are held, in_ready_o drops until a transfer frees
// an entry.
// Configuration (cfg_we_i, cfg_index_i, cfg_data_i) writes retry_limit,
// timeout_count and prescale_ticks at indexes 0, 1, 2; write only while idle.
// Reset clears the link state, timer and saved frame, empties the output
// buffer and loads the register defaults (5, 50, 4).
module frame_retransmit_controller import frc_pkg::*; #(
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            cmd_i,
  input  logic [63:0]           frame_in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [63:0]           frame_out_o,
  output logic                  is_retry_o,
  output logic [3:0]            attempt_number_o,
  output logic                  gave_up_o
);

  logic accept;
  logic res_valid;
  res_t res;
  res_t out_res;

  assign accept = in_valid_i && in_ready_o;

  frc_core #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .cmd_i      (cmd_i),
    .frame_in_i (frame_in_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  frc_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res),
    .ready_o    (in_ready_o),
    .valid_o    (out_valid_o),
    .pop_ready_i(out_ready_i),
    .data_o     (out_res)
  );

  assign frame_out_o      = out_res.frame_out;
  assign is_retry_o       = out_res.is_retry;
  assign attempt_number_o = out_res.attempt_number;
  assign gave_up_o        = out_res.gave_up;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
  import frc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 800_000;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned LONG_HOLD    = 80;
  localparam int unsigned ZERO_TO_TICKS = 40;
  localparam logic [2:0]  CMD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0]  CMD_UNUSED_LAST  = 3'd7;
  localparam logic [63:0] FRAME_MASK = (FRAME_BYTES_DEF >= 8) ? {64{1'b1}} :
                                       (64'h1 << (8 * FRAME_BYTES_DEF)) - 64'h1;

  // Tracks link state, retry count and the prescaled timer, and queues the
  // frames the controller should put out, oldest first.
  class retransmit_model;
    logic [3:0]  retry_limit;
    logic [15:0] timeout_count;
    logic [7:0]  prescale_ticks;
    logic [1:0]  link;
    logic [3:0]  retries;
    logic [63:0] saved;
    logic [7:0]  presc_cnt;
    logic [15:0] countdown;
    bit          expired;
    res_t        pending_frames[$];
    int unsigned errors, n_commands, n_sends, n_retries, n_give_ups;

    function new();
      retry_limit    = RETRY_LIMIT_RST;
      timeout_count  = TIMEOUT_COUNT_RST;
      prescale_ticks = PRESCALE_TICKS_RST;
      link      = LINK_IDLE;
      retries   = '0;
      saved     = '0;
      presc_cnt = '0;
      countdown = '0;
      expired   = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_RETRY_LIMIT:    retry_limit    = data[3:0];
        CFG_TIMEOUT_COUNT:  timeout_count  = data[15:0];
        CFG_PRESCALE_TICKS: prescale_ticks = data[7:0];
        default: ;
      endcase
    endfunction

    function void push_frame(logic [63:0] frame, bit retry, logic [3:0] attempt, bit gave);
      res_t r;
      r.frame_out      = frame;
      r.is_retry       = retry;
      r.attempt_number = attempt;
      r.gave_up        = gave;
      pending_frames.push_back(r);
    endfunction

    function void arm_timer();
      countdown = timeout_count;
      presc_cnt = '0;
      expired   = 1'b0;
    endfunction

    function void retry_or_give_up();
      if (retries < retry_limit) begin
        retries = retries + 4'd1;
        push_frame(saved, 1'b1, retries, 1'b0);
        arm_timer();
        n_retries++;
      end else begin
        link = LINK_IDLE;
        push_frame(64'h0, 1'b0, retries, 1'b1);
        n_give_ups++;
      end
    endfunction

    function void note_command(logic [2:0] cmd, logic [63:0] frame);
      n_commands++;
      case (cmd)
        CMD_TICK: begin
          presc_cnt = presc_cnt + 8'd1;
          if (presc_cnt >= prescale_ticks) begin
            presc_cnt = '0;
            countdown = countdown - 16'd1;
            if (countdown == 16'd0) expired = 1'b1;
          end
        end
        CMD_POLL: begin
          // any non-idle, non-nacked state behaves as waiting
          if (link == LINK_IDLE) retries = '0;
          else if (link == LINK_NACKED || expired) retry_or_give_up();
        end
        CMD_SEND: begin
          saved = frame & FRAME_MASK;
          push_frame(saved, 1'b0, 4'd0, 1'b0);
          arm_timer();
          retries = '0;
          link    = LINK_WAITING;
          n_sends++;
        end
        CMD_ACK:  link = LINK_IDLE;
        CMD_NACK: link = LINK_NACKED;
        default: ;
      endcase
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= 10) $display("[%0t] ERROR %s", $time, what);
    endfunction

    function void check_frame(res_t got);
      res_t exp;
      if (pending_frames.size() == 0) begin
        flag($sformatf("unexpected result frame_out %h gave_up %b",
                       got.frame_out, got.gave_up));
        return;
      end
      exp = pending_frames.pop_front();
      if (got.frame_out !== exp.frame_out)
        flag($sformatf("frame_out exp %h got %h", exp.frame_out, got.frame_out));
      if (got.is_retry !== exp.is_retry)
        flag($sformatf("is_retry exp %b got %b", exp.is_retry, got.is_retry));
      if (got.attempt_number !== exp.attempt_number)
        flag($sformatf("attempt_number exp %0d got %0d",
                       exp.attempt_number, got.attempt_number));
      if (got.gave_up !== exp.gave_up)
        flag($sformatf("gave_up exp %b got %b", exp.gave_up, got.gave_up));
    endfunction

    function int unsigned pending();
      return pending_frames.size();
    endfunction
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [2:0]            cmd_i       = CMD_TICK;
  logic [63:0]           frame_in_i  = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [63:0]           frame_out_o;
  logic                  is_retry_o;
  logic [3:0]            attempt_number_o;
  logic                  gave_up_o;

  retransmit_model model = new();
  int unsigned     tx_gap_pct;
  int unsigned     rx_stall_pct;
  bit              long_hold_req;
  int unsigned     in_stall_cycles;

  frame_retransmit_controller dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .frame_in_i       (frame_in_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .frame_out_o      (frame_out_o),
    .is_retry_o       (is_retry_o),
    .attempt_number_o (attempt_number_o),
    .gave_up_o        (gave_up_o)
  );

  always #5 clk_i = ~clk_i;

  // Check the result transfer before noting the command of the same edge.
  always @(posedge clk_i) begin : monitor
    res_t got;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.frame_out      = frame_out_o;
        got.is_retry       = is_retry_o;
        got.attempt_number = attempt_number_o;
        got.gave_up        = gave_up_o;
        model.check_frame(got);
      end
      if (in_valid_i && in_ready_o) model.note_command(cmd_i, frame_in_i);
      if (in_valid_i && !in_ready_o) in_stall_cycles++;
    end
  end

  initial begin : receiver
    int unsigned n;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end else if (rst_ni && $urandom_range(1, 100) <= rx_stall_pct) begin
        out_ready_i <= 1'b0;
        n = $urandom_range(1, 17);
        repeat (n) @(negedge clk_i);
      end else begin
        out_ready_i <= rst_ni;
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Run exceeded %0d cycles", CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // Called at a falling edge; returns at a falling edge with valid still high.
  task automatic drive_item(input logic [2:0] cmd, input logic [63:0] frame);
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    frame_in_i <= frame;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic maybe_gap();
    int unsigned n;
    if ($urandom_range(1, 100) <= tx_gap_pct) begin
      in_valid_i <= 1'b0;
      n = $urandom_range(1, 17);
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (model.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    model.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Unused upper data bits carry noise; the block must ignore them.
  task automatic set_timer_cfg(input logic [3:0] rl, input logic [15:0] to,
                               input logic [7:0] ps);
    logic [11:0] hi_rl;
    logic [7:0]  hi_ps;
    hi_rl = 12'($urandom);
    hi_ps = 8'($urandom);
    write_reg(CFG_RETRY_LIMIT, {hi_rl, rl});
    write_reg(CFG_TIMEOUT_COUNT, to);
    write_reg(CFG_PRESCALE_TICKS, {hi_ps, ps});
  endtask

  function automatic logic [63:0] rand_frame();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [2:0] episode_cmd();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return CMD_TICK;
    if (r < 85) return CMD_POLL;
    if (r < 93) return CMD_NACK;
    return CMD_ACK;
  endfunction

  // Mostly send-led episodes of ticks, polls, nacks and acks, the rest single random codes.
  task automatic random_items(input int unsigned n);
    int unsigned done_cnt, len;
    logic [2:0]  c;
    done_cnt = 0;
    while (done_cnt < n) begin
      if ($urandom_range(0, 99) < 85) begin
        maybe_gap();
        drive_item(CMD_SEND, rand_frame());
        len = $urandom_range(4, 20);
        done_cnt += len + 1;
        repeat (len) begin
          maybe_gap();
          drive_item(episode_cmd(), rand_frame());
        end
      end else begin
        c = 3'($urandom_range(CMD_TICK, CMD_UNUSED_LAST));
        maybe_gap();
        drive_item(c, rand_frame());
        if (c < CMD_UNUSED_FIRST) done_cnt++;
      end
    end
  endtask

  task automatic run_phase(input logic [3:0] rl, input logic [15:0] to, input logic [7:0] ps,
                           input int unsigned n, input int unsigned gap, input int unsigned stall);
    drain();
    set_timer_cfg(rl, to, ps);
    tx_gap_pct   = gap;
    rx_stall_pct = stall;
    random_items(n);
  endtask

  initial begin : stimulus
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // defaults: idle poll, retry of the reset frame, field extremes, unused codes
    drive_item(CMD_POLL, rand_frame());
    drive_item(CMD_NACK, rand_frame());
    drive_item(CMD_POLL, rand_frame());
    drive_item(CMD_SEND, {64{1'b1}});
    drive_item(CMD_SEND, 64'h0);
    drive_item(CMD_SEND, rand_frame());
    drive_item(CMD_UNUSED_FIRST, rand_frame());
    drive_item(CMD_UNUSED_FIRST + 3'd1, rand_frame());
    drive_item(CMD_UNUSED_LAST, rand_frame());
    drive_item(CMD_ACK, rand_frame());
    drive_item(CMD_POLL, rand_frame());
    // nacked link: retry on every poll until the limit, then give up
    drive_item(CMD_NACK, rand_frame());
    repeat (6) drive_item(CMD_POLL, rand_frame());
    drive_item(CMD_POLL, rand_frame());

    // zero prescale: every tick expires a one-period timeout
    drain();
    set_timer_cfg(4'd2, 16'd1, 8'd0);
    drive_item(CMD_SEND, rand_frame());
    drive_item(CMD_POLL, rand_frame());
    repeat (3) begin
      drive_item(CMD_TICK, rand_frame());
      drive_item(CMD_POLL, rand_frame());
    end

    // zero timeout: the first decrement wraps, so no early expiry
    drain();
    set_timer_cfg(4'd1, 16'd0, 8'd1);
    drive_item(CMD_SEND, rand_frame());
    drive_item(CMD_POLL, rand_frame());
    repeat (ZERO_TO_TICKS) drive_item(CMD_TICK, 64'h0);
    drive_item(CMD_POLL, rand_frame());

    run_phase(4'd15, 16'hFFFF, 8'hFF, 120, 20, 20);
    run_phase(4'd0, 16'd1, 8'd1, 150, 10, 30);
    run_phase(4'd3, 16'd2, 8'd0, 200, 30, 10);
    run_phase(4'($urandom), 16'($urandom_range(1, 6)), 8'($urandom_range(0, 3)), 200, 0, 20);
    run_phase(4'd15, 16'd1, 8'd2, 150, 20, 0);

    // receiver holds off while sends keep coming, so the output buffer fills
    drain();
    tx_gap_pct    = 0;
    rx_stall_pct  = 0;
    long_hold_req = 1'b1;
    repeat (12) drive_item(CMD_SEND, rand_frame());

    run_phase(4'($urandom), 16'($urandom_range(1, 4)), 8'($urandom_range(0, 2)), 150, 0, 0);

    drain();
    $display("Ran %0d commands: %0d sends, %0d retransmissions, %0d give-ups",
             model.n_commands, model.n_sends, model.n_retries, model.n_give_ups);
    $display("Covered register extremes, zero timeout, and %0d back-pressured input cycles",
             in_stall_cycles);
    if (model.errors == 0 && model.pending() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
